>>> hdl/visibility_gain_calibration_unit_defines.svh
// Assertion macros shared by the gain calibration unit
`ifndef VISIBILITY_GAIN_CALIBRATION_UNIT_DEFINES_SVH
`define VISIBILITY_GAIN_CALIBRATION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/vgc_pkg.sv
// Shared constants, codes and types of the gain calibration unit
`timescale 1ns / 1ps
package vgc_pkg;
  localparam int NUM_ANTENNAS = 64;
  localparam int NUM_BEAMS    = 64;
  localparam int ROWS         = NUM_ANTENNAS * NUM_BEAMS;
  localparam int ROW_W        = $clog2(ROWS);

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam int QBITS        = 24;
  localparam int DIV_LAT      = QBITS + 2;
  localparam int MAG_W        = 57;
  localparam int DEN_W        = 64;
  localparam int PRE_SHIFT    = 4;

  localparam logic [47:0] THR_RESET = 48'd28147;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAL   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_DET_SMALL    = 2'd1,
    ST_GAIN_INVALID = 2'd2
  } vgc_status_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] re;
    logic [15:0] im;
  } vgc_gain_t;

  typedef struct packed {
    logic             cmd;
    logic [1:0]       pol;
    logic [23:0]      vis_re;
    logic [23:0]      vis_im;
    logic [3:0][15:0] g_re;
    logic [3:0][15:0] g_im;
    logic             ok;
  } vgc_entry_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  nempty;
  } vgc_fifo_stat_t;

  typedef struct packed {
    vgc_status_t status;
    logic        zero;
  } vgc_side_t;
endpackage

>>> hdl/vgc_ifs.sv
// Channel interfaces of the gain calibration unit
`timescale 1ns / 1ps
interface vgc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [5:0]         ant_a;
  logic [5:0]         ant_b;
  logic [5:0]         beam_a;
  logic [5:0]         beam_b;
  logic [1:0]         pol_product;
  logic signed [23:0] vis_re;
  logic signed [23:0] vis_im;
  logic signed [15:0] gain_re;
  logic signed [15:0] gain_im;
  logic               gain_ok;
  modport source (output valid, cmd, ant_a, ant_b, beam_a, beam_b, pol_product,
                  vis_re, vis_im, gain_re, gain_im, gain_ok, input ready);
  modport sink (input valid, cmd, ant_a, ant_b, beam_a, beam_b, pol_product,
                vis_re, vis_im, gain_re, gain_im, gain_ok, output ready);
endinterface

interface vgc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_re;
  logic signed [23:0] out_im;
  logic [1:0]         status;
  modport source (output valid, out_re, out_im, status, input ready);
  modport sink (input valid, out_re, out_im, status, output ready);
endinterface

interface vgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] det_threshold_sq;
  modport source (output valid, det_threshold_sq, input ready);
  modport sink (input valid, det_threshold_sq, output ready);
endinterface

>>> hdl/vgc_front.sv
// Front end: accept words, clear and access the gain table, classify items
`timescale 1ns / 1ps
module vgc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  vgc_in_if.sink                 in_word,
  input  vgc_pkg::vgc_fifo_stat_t fstat,
  output logic                   push,
  output vgc_pkg::vgc_entry_t    push_data
);
  import vgc_pkg::*;

  vgc_gain_t mem_x [ROWS];
  vgc_gain_t mem_y [ROWS];

  logic             clearing_r;
  logic [ROW_W-1:0] clr_cnt_r;
  logic             acc;
  logic             rng_a;
  logic             rng_b;
  logic [ROW_W-1:0] row_a;
  logic [ROW_W-1:0] row_b;
  logic             we_x;
  logic             we_y;
  logic [ROW_W-1:0] waddr;
  vgc_gain_t        wdata;
  vgc_gain_t        ax_r, ay_r, bx_r, by_r;
  logic             f1_v_r;
  logic             f1_cmd_r;
  logic             f1_rng_r;
  logic [1:0]       f1_pol_r;
  logic [23:0]      f1_vre_r;
  logic [23:0]      f1_vim_r;

  assign in_word.ready = !clearing_r &&
                         ((int'(fstat.count) + int'(f1_v_r)) < FIFO_DEPTH);
  assign acc = in_word.valid && in_word.ready;

  always_comb begin
    rng_a = (int'(in_word.ant_a) < NUM_ANTENNAS) && (int'(in_word.beam_a) < NUM_BEAMS);
    rng_b = (int'(in_word.ant_b) < NUM_ANTENNAS) && (int'(in_word.beam_b) < NUM_BEAMS);
    row_a = rng_a ? ROW_W'(int'(in_word.ant_a) * NUM_BEAMS + int'(in_word.beam_a)) : '0;
    row_b = rng_b ? ROW_W'(int'(in_word.ant_b) * NUM_BEAMS + int'(in_word.beam_b)) : '0;
    wdata.valid = in_word.gain_ok;
    wdata.re    = in_word.gain_re;
    wdata.im    = in_word.gain_im;
    waddr = row_a;
    we_x  = 1'b0;
    we_y  = 1'b0;
    if (clearing_r) begin
      waddr = clr_cnt_r;
      wdata = '0;
      we_x  = 1'b1;
      we_y  = 1'b1;
    end else if (acc && (in_word.cmd == CMD_WRITE) && rng_a) begin
      we_x = !in_word.pol_product[0];
      we_y = in_word.pol_product[0];
    end
  end

  always_ff @(posedge clk) begin
    if (we_x) mem_x[waddr] <= wdata;
    if (we_y) mem_y[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ax_r     <= mem_x[row_a];
      ay_r     <= mem_y[row_a];
      bx_r     <= mem_x[row_b];
      by_r     <= mem_y[row_b];
      f1_cmd_r <= in_word.cmd;
      f1_rng_r <= rng_a && rng_b;
      f1_pol_r <= in_word.pol_product;
      f1_vre_r <= in_word.vis_re;
      f1_vim_r <= in_word.vis_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      f1_v_r     <= 1'b0;
    end else begin
      f1_v_r <= acc;
      if (clearing_r) begin
        if (clr_cnt_r == ROW_W'(ROWS - 1)) clearing_r <= 1'b0;
        else clr_cnt_r <= clr_cnt_r + ROW_W'(1);
      end
    end
  end

  always_comb begin
    push             = f1_v_r;
    push_data.cmd    = f1_cmd_r;
    push_data.pol    = f1_pol_r;
    push_data.vis_re = f1_vre_r;
    push_data.vis_im = f1_vim_r;
    push_data.g_re   = {by_r.re, bx_r.re, ay_r.re, ax_r.re};
    push_data.g_im   = {by_r.im, bx_r.im, ay_r.im, ax_r.im};
    push_data.ok     = f1_rng_r && ax_r.valid && ay_r.valid && bx_r.valid && by_r.valid;
  end
endmodule

>>> hdl/vgc_fifo.sv
// Short queue between the front end and the arithmetic back end
`timescale 1ns / 1ps
`include "visibility_gain_calibration_unit_defines.svh"
module vgc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  vgc_pkg::vgc_entry_t     push_data,
  input  logic                    pop,
  output vgc_pkg::vgc_entry_t     head,
  output vgc_pkg::vgc_fifo_stat_t stat
);
  import vgc_pkg::*;

  vgc_entry_t            ent_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r;
  logic [FIFO_PTR_W-1:0] rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign head        = ent_r[rp_r];
  assign stat.count  = cnt_r;
  assign stat.nempty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_PTR_W'(1);
      if (pop) rp_r <= rp_r + FIFO_PTR_W'(1);
      cnt_r <= cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  `VGC_ASSERT_NOW(a_no_overflow, push && !pop, cnt_r != FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")
  `VGC_ASSERT_NOW(a_no_underflow, pop, cnt_r != '0, "queue underflow")
  `VGC_ASSERT_NEXT(a_head_hold, !pop && (cnt_r != '0), $stable(head), "queue head changed")
endmodule

>>> hdl/vgc_div.sv
// Pipelined restoring divider with saturation to a signed 24-bit quotient
`timescale 1ns / 1ps
module vgc_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vgc_pkg::MAG_W-1:0] mag,
  input  logic                      neg,
  input  logic [vgc_pkg::DEN_W-1:0] den,
  output logic [vgc_pkg::QBITS-1:0] quot
);
  import vgc_pkg::*;

  logic [DEN_W-1:0] rem_r [QBITS];
  logic [DEN_W-1:0] den_r [QBITS];
  logic [QBITS-1:0] q_r   [1:QBITS];
  logic             neg_r [QBITS+1];
  logic             sat_r [QBITS+1];
  logic [DEN_W:0]   rem2  [1:QBITS];
  logic [DEN_W:0]   diff  [1:QBITS];
  logic             ge    [1:QBITS];
  logic [QBITS-1:0] limit;
  logic [QBITS-1:0] qs;
  logic [QBITS-1:0] res;

  always_comb begin
    for (int k = 1; k <= QBITS; k++) begin
      rem2[k] = {rem_r[k-1], 1'b0};
      diff[k] = rem2[k] - {1'b0, den_r[k-1]};
      ge[k]   = rem2[k] >= {1'b0, den_r[k-1]};
    end
    limit = neg_r[QBITS] ? QBITS'(1 << (QBITS - 1)) : QBITS'((1 << (QBITS - 1)) - 1);
    qs    = (sat_r[QBITS] || (q_r[QBITS] > limit)) ? limit : q_r[QBITS];
    res   = neg_r[QBITS] ? (~qs + QBITS'(1)) : qs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'({mag, {PRE_SHIFT{1'b0}}});
      den_r[0] <= den;
      neg_r[0] <= neg;
      sat_r[0] <= ((DEN_W + 1)'({mag, {PRE_SHIFT{1'b0}}})) >= {1'b0, den};
      for (int k = 1; k <= QBITS; k++) begin
        if (k < QBITS) begin
          rem_r[k] <= ge[k] ? diff[k][DEN_W-1:0] : rem2[k][DEN_W-1:0];
          den_r[k] <= den_r[k-1];
        end
        if (k == 1) q_r[k] <= QBITS'(ge[k]);
        else q_r[k] <= {q_r[(k > 1) ? k - 1 : 1][QBITS-2:0], ge[k]};
        neg_r[k] <= neg_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
      quot <= res;
    end
  end
endmodule

>>> hdl/vgc_back.sv
// Back end: gain products, determinant check, division and result register
`timescale 1ns / 1ps
`include "visibility_gain_calibration_unit_defines.svh"
module vgc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vgc_pkg::vgc_entry_t     head,
  input  vgc_pkg::vgc_fifo_stat_t fstat,
  output logic                    pop,
  vgc_cfg_if.sink                 cfg_word,
  vgc_out_if.source               out_word
);
  import vgc_pkg::*;

  logic [47:0] thr_r;
  logic        adv;

  logic signed [15:0] gre [4];
  logic signed [15:0] gim [4];
  logic signed [31:0] sq_re [4];
  logic signed [31:0] sq_im [4];
  logic signed [15:0] ar, ai, br, bi;
  logic signed [31:0] t_rr, t_ii, t_ir, t_ri;

  logic               b1_v_r, b1_cmd_r, b1_ok_r;
  logic [31:0]        a_r [4];
  logic signed [32:0] mr_r, mi_r;
  logic signed [23:0] vre1_r, vim1_r;

  logic [63:0]        pp01, pp23;
  logic signed [65:0] mrr_f, mii_f;
  logic signed [MAG_W-1:0] vrmr_f, vimi_f, vimr_f, vrmi_f;
  logic               b2_v_r, b2_cmd_r, b2_ok_r;
  logic [31:0]        p01_r, p23_r;
  logic [63:0]        mrr_r, mii_r;
  logic signed [MAG_W-1:0] vrmr_r, vimi_r, vimr_r, vrmi_r;

  logic               b3_v_r, b3_cmd_r, b3_ok_r;
  logic [63:0]        dprod_r;
  logic [DEN_W-1:0]   den3_r;
  logic signed [MAG_W-1:0] nre3_r, nim3_r;

  logic               b4_v_r, b4_cmd_r, b4_ok_r;
  logic               big4_r;
  logic [47:0]        dsq4_r;
  logic [DEN_W-1:0]   den4_r;
  logic [MAG_W-1:0]   magre4_r, magim4_r;
  logic               negre4_r, negim4_r;

  vgc_side_t          side;
  vgc_side_t          sd_r  [DIV_LAT];
  logic               sdv_r [DIV_LAT];
  logic [QBITS-1:0]   qre, qim;

  logic               out_valid_r;
  logic [23:0]        out_re_r, out_im_r;
  vgc_status_t        out_st_r;

  assign cfg_word.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (cfg_word.valid) thr_r <= cfg_word.det_threshold_sq;
  end

  assign adv = out_word.ready || !out_valid_r;
  assign pop = adv && fstat.nempty;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      gre[k]   = $signed(head.g_re[k]);
      gim[k]   = $signed(head.g_im[k]);
      sq_re[k] = gre[k] * gre[k];
      sq_im[k] = gim[k] * gim[k];
    end
    ar   = gre[{1'b0, head.pol[1]}];
    ai   = gim[{1'b0, head.pol[1]}];
    br   = gre[{1'b1, head.pol[0]}];
    bi   = gim[{1'b1, head.pol[0]}];
    t_rr = ar * br;
    t_ii = ai * bi;
    t_ir = ai * br;
    t_ri = ar * bi;
  end

  always_comb begin
    pp01   = 64'(a_r[0]) * 64'(a_r[1]);
    pp23   = 64'(a_r[2]) * 64'(a_r[3]);
    mrr_f  = mr_r * mr_r;
    mii_f  = mi_r * mi_r;
    vrmr_f = vre1_r * mr_r;
    vimi_f = vim1_r * mi_r;
    vimr_f = vim1_r * mr_r;
    vrmi_f = vre1_r * mi_r;
  end

  always_comb begin
    side.status = ST_OK;
    side.zero   = 1'b0;
    if (b4_cmd_r == CMD_WRITE) begin
      side.zero = 1'b1;
    end else if (!b4_ok_r) begin
      side.status = ST_GAIN_INVALID;
      side.zero   = 1'b1;
    end else if ((!big4_r && (dsq4_r < thr_r)) || (den4_r == '0)) begin
      side.status = ST_DET_SMALL;
      side.zero   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) a_r[k] <= $unsigned(sq_re[k]) + $unsigned(sq_im[k]);
      mr_r     <= {t_rr[31], t_rr} + {t_ii[31], t_ii};
      mi_r     <= {t_ir[31], t_ir} - {t_ri[31], t_ri};
      vre1_r   <= head.vis_re;
      vim1_r   <= head.vis_im;
      b1_cmd_r <= head.cmd;
      b1_ok_r  <= head.ok;

      p01_r    <= (pp01[63:62] != 2'b00) ? 32'hFFFF_FFFF : pp01[61:30];
      p23_r    <= (pp23[63:62] != 2'b00) ? 32'hFFFF_FFFF : pp23[61:30];
      mrr_r    <= mrr_f[63:0];
      mii_r    <= mii_f[63:0];
      vrmr_r   <= vrmr_f;
      vimi_r   <= vimi_f;
      vimr_r   <= vimr_f;
      vrmi_r   <= vrmi_f;
      b2_cmd_r <= b1_cmd_r;
      b2_ok_r  <= b1_ok_r;

      dprod_r  <= 64'(p01_r) * 64'(p23_r);
      den3_r   <= mrr_r + mii_r;
      nre3_r   <= vrmr_r + vimi_r;
      nim3_r   <= vimr_r - vrmi_r;
      b3_cmd_r <= b2_cmd_r;
      b3_ok_r  <= b2_ok_r;

      big4_r   <= (dprod_r[63:52] != '0);
      dsq4_r   <= 48'(dprod_r[51:28]) * 48'(dprod_r[51:28]);
      den4_r   <= den3_r;
      negre4_r <= nre3_r[MAG_W-1];
      negim4_r <= nim3_r[MAG_W-1];
      magre4_r <= nre3_r[MAG_W-1] ? MAG_W'(-nre3_r) : MAG_W'(nre3_r);
      magim4_r <= nim3_r[MAG_W-1] ? MAG_W'(-nim3_r) : MAG_W'(nim3_r);
      b4_cmd_r <= b3_cmd_r;
      b4_ok_r  <= b3_ok_r;

      sd_r[0] <= side;
      for (int j = 1; j < DIV_LAT; j++) sd_r[j] <= sd_r[j-1];

      out_re_r <= sd_r[DIV_LAT-1].zero ? '0 : qre;
      out_im_r <= sd_r[DIV_LAT-1].zero ? '0 : qim;
      out_st_r <= sd_r[DIV_LAT-1].status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      b4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < DIV_LAT; j++) sdv_r[j] <= 1'b0;
    end else if (adv) begin
      b1_v_r      <= pop;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      b4_v_r      <= b3_v_r;
      sdv_r[0]    <= b4_v_r;
      for (int j = 1; j < DIV_LAT; j++) sdv_r[j] <= sdv_r[j-1];
      out_valid_r <= sdv_r[DIV_LAT-1];
    end
  end

  vgc_div u_div_re (
    .clk  (clk),
    .en   (adv),
    .mag  (magre4_r),
    .neg  (negre4_r),
    .den  (den4_r),
    .quot (qre)
  );

  vgc_div u_div_im (
    .clk  (clk),
    .en   (adv),
    .mag  (magim4_r),
    .neg  (negim4_r),
    .den  (den4_r),
    .quot (qim)
  );

  assign out_word.valid  = out_valid_r;
  assign out_word.out_re = out_re_r;
  assign out_word.out_im = out_im_r;
  assign out_word.status = out_st_r;

  `VGC_ASSERT_NOW(a_err_zero, out_valid_r && (out_st_r != ST_OK), (out_re_r == '0) && (out_im_r == '0), "error result not zero")
  `VGC_ASSERT_NEXT(a_pop_enters, pop, b1_v_r, "popped item lost")
  `VGC_ASSERT_NEXT(a_tail_out, adv && sdv_r[DIV_LAT-1], out_valid_r, "result lost at output")
endmodule

>>> hdl/visibility_gain_calibration_unit.sv
// Top level of the visibility gain calibration unit
//
// Channels: in_word carries gain writes (cmd 0) and visibility samples
// (cmd 1); out_word returns one result word per input word, in order;
// cfg_word writes the squared determinant threshold and is always ready.
// Throughput: one word per cycle in both directions while out_word.ready
// stays high and no clearing pass runs.
// Path: an accepted word passes the table read register, the queue,
// four arithmetic stages, then the 26-stage divider and the output
// register before its result is valid.
// Gain table: two single-write, dual-read memories (X and Y pol) of
// 4096 rows each; a write word lands at its accept edge, so a sample
// accepted in the next cycle already sees it.
// Reset: a clearing pass over all 4096 rows zeroes the table valid bits,
// with in_word.ready low; cfg writes are taken during it.
// Stall: while a result waits on a low out_word.ready the back end
// holds; the queue takes up to four more words before in_word.ready drops.
`timescale 1ns / 1ps
module visibility_gain_calibration_unit (
  input logic       clk,
  input logic       rst_n,
  vgc_in_if.sink    in_word,
  vgc_out_if.source out_word,
  vgc_cfg_if.sink   cfg_word
);
  import vgc_pkg::*;

  logic           push;
  logic           pop;
  vgc_entry_t     push_data;
  vgc_entry_t     head;
  vgc_fifo_stat_t fstat;

  vgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .fstat     (fstat),
    .push      (push),
    .push_data (push_data)
  );

  vgc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fstat)
  );

  vgc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .fstat    (fstat),
    .pop      (pop),
    .cfg_word (cfg_word),
    .out_word (out_word)
  );
endmodule

>>> verif/visibility_gain_calibration_unit_test.sv
// Self-checking testbench of the visibility gain calibration unit
`timescale 1ns / 1ps
module visibility_gain_calibration_unit_test;
  import vgc_pkg::*;

  typedef struct {
    logic cmd;
    logic [5:0] ant_a, ant_b, beam_a, beam_b;
    logic [1:0] pol;
    logic [23:0] vis_re, vis_im;
    logic [15:0] gain_re, gain_im;
    logic gain_ok;
  } sample_word_t;

  typedef struct {
    logic [23:0] re, im;
    logic [1:0] status;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  vgc_in_if in_ch();
  vgc_out_if out_ch();
  vgc_cfg_if cfg_ch();

  visibility_gain_calibration_unit dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_ch.sink), .out_word(out_ch.source),
    .cfg_word(cfg_ch.sink)
  );

  logic [31:0] gain_tab [0:ROWS*2-1];
  bit gain_vld [0:ROWS*2-1];
  bit written [0:ROWS*2-1];
  logic [47:0] thr_model;

  sample_word_t pending_q[$];
  cal_result_t expected_q[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int errors = 0;
  longint cycles = 0;
  int sent_total = 0;

  function automatic longint sx(logic [63:0] v, int w);
    sx = longint'(v << (64 - w)) >>> (64 - w);
  endfunction

  function automatic longint scaled_quot(longint n, longint unsigned d);
    bit neg;
    longint unsigned mag, lim, q, r;
    neg = n < 0;
    mag = neg ? -n : n;
    lim = neg ? 64'd8388608 : 64'd8388607;
    q = mag / d;
    r = mag % d;
    if (q > lim) q = lim;
    else begin
      for (int i = 0; i < 28; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q++;
        end
        if (q > lim) begin
          q = lim;
          break;
        end
      end
    end
    scaled_quot = neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned pair_mag(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b) >> 30;
    pair_mag = (p > 64'hFFFFFFFF) ? 64'hFFFFFFFF : p;
  endfunction

  function automatic cal_result_t calibrate(sample_word_t w);
    cal_result_t r;
    longint gr[4], gi[4];
    longint unsigned a[4], d, den;
    longint mr, mi, vr, vi;
    int idx;
    bit ok;
    r.re = '0; r.im = '0; r.status = ST_OK;
    if (w.cmd == CMD_WRITE) begin
      idx = (w.ant_a * NUM_BEAMS + w.beam_a) * 2 + w.pol[0];
      gain_tab[idx] = {w.gain_re, w.gain_im};
      gain_vld[idx] = w.gain_ok;
      written[idx] = 1'b1;
      return r;
    end
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx = (k < 2) ? (w.ant_a * NUM_BEAMS + w.beam_a) * 2 + k
                    : (w.ant_b * NUM_BEAMS + w.beam_b) * 2 + k - 2;
      if (!gain_vld[idx]) ok = 1'b0;
      else begin
        gr[k] = sx(gain_tab[idx][31:16], 16);
        gi[k] = sx(gain_tab[idx][15:0], 16);
        a[k] = gr[k] * gr[k] + gi[k] * gi[k];
      end
    end
    if (!ok) begin
      r.status = ST_GAIN_INVALID;
      return r;
    end
    d = (pair_mag(a[0], a[1]) * pair_mag(a[2], a[3])) >> 28;
    if (d < (64'd1 << 24) && d * d < thr_model) begin
      r.status = ST_DET_SMALL;
      return r;
    end
    mr = gr[w.pol[1]] * gr[2 + w.pol[0]] + gi[w.pol[1]] * gi[2 + w.pol[0]];
    mi = gi[w.pol[1]] * gr[2 + w.pol[0]] - gr[w.pol[1]] * gi[2 + w.pol[0]];
    den = mr * mr + mi * mi;
    if (den == 0) begin
      r.status = ST_DET_SMALL;
      return r;
    end
    vr = sx(w.vis_re, 24);
    vi = sx(w.vis_im, 24);
    r.re = 24'(scaled_quot(vr * mr + vi * mi, den));
    r.im = 24'(scaled_quot(vi * mr - vr * mi, den));
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(calibrate(pending_q.pop_front()));
        sent_total++;
      end
      if ((in_ch.valid && !in_ch.ready) ||
          (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= pending_q[0].cmd;
        in_ch.ant_a <= pending_q[0].ant_a;
        in_ch.ant_b <= pending_q[0].ant_b;
        in_ch.beam_a <= pending_q[0].beam_a;
        in_ch.beam_b <= pending_q[0].beam_b;
        in_ch.pol_product <= pending_q[0].pol;
        in_ch.vis_re <= pending_q[0].vis_re;
        in_ch.vis_im <= pending_q[0].vis_im;
        in_ch.gain_re <= pending_q[0].gain_re;
        in_ch.gain_im <= pending_q[0].gain_im;
        in_ch.gain_ok <= pending_q[0].gain_ok;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cal_result_t e;
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word re=%h im=%h st=%0d",
                                   out_ch.out_re, out_ch.out_im, out_ch.status);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.out_re !== e.re || out_ch.out_im !== e.im ||
            out_ch.status !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                     e.re, e.im, e.status, out_ch.out_re, out_ch.out_im, out_ch.status);
        end
      end
    end
    out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic add_gain(int ant, int beam, int pol, logic [15:0] gre, logic [15:0] gim,
                          bit ok);
    sample_word_t w;
    w = '{default: '0};
    w.cmd = CMD_WRITE; w.ant_a = 6'(ant); w.beam_a = 6'(beam); w.pol = 2'(pol);
    w.gain_re = gre; w.gain_im = gim; w.gain_ok = ok;
    w.ant_b = 6'($urandom); w.beam_b = 6'($urandom);
    w.vis_re = 24'($urandom); w.vis_im = 24'($urandom);
    pending_q.push_back(w);
  endtask

  task automatic add_sample(int aa, int ba, int ab, int bb, int pol, logic [23:0] vre,
                            logic [23:0] vim);
    sample_word_t w;
    w = '{default: '0};
    w.cmd = CMD_CAL; w.ant_a = 6'(aa); w.beam_a = 6'(ba); w.ant_b = 6'(ab);
    w.beam_b = 6'(bb);
    w.pol = 2'(pol); w.vis_re = vre; w.vis_im = vim;
    w.gain_re = 16'($urandom); w.gain_im = 16'($urandom); w.gain_ok = 1'($urandom);
    pending_q.push_back(w);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_threshold(logic [47:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.det_threshold_sq <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    thr_model = v;
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(5))
      0: rand_gain = 16'h8000;
      1: rand_gain = 16'h7FFF;
      2: rand_gain = 16'($urandom_range(8) - 4);
      default: rand_gain = 16'($urandom);
    endcase
  endfunction

  // gain sets live on a few antenna/beam slots so that samples find them
  task automatic random_phase(int n);
    int aa, ba, ab, bb;
    for (int i = 0; i < n; i++) begin
      aa = $urandom_range(7); ba = $urandom_range(3);
      ab = $urandom_range(7); bb = $urandom_range(3);
      if ($urandom_range(99) < 10) begin
        aa = $urandom; ba = $urandom; ab = $urandom; bb = $urandom;
      end
      if ($urandom_range(99) < 35) begin
        add_gain(aa, ba, $urandom, rand_gain(), rand_gain(), $urandom_range(99) < 92);
      end else begin
        add_sample(aa, ba, ab, bb, $urandom, 24'($urandom), 24'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.ant_a = '0; in_ch.ant_b = '0;
    in_ch.beam_a = '0; in_ch.beam_b = '0; in_ch.pol_product = '0;
    in_ch.vis_re = '0; in_ch.vis_im = '0; in_ch.gain_re = '0; in_ch.gain_im = '0;
    in_ch.gain_ok = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.det_threshold_sq = '0;
    thr_model = THR_RESET;
    for (int i = 0; i < ROWS * 2; i++) begin
      gain_vld[i] = 1'b0;
      written[i] = 1'b0;
      gain_tab[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: missing gain, unity gains, extremes, small det, zero term
    add_sample(0, 0, 1, 0, 0, 24'h7FFFFF, 24'h800000);
    for (int p = 0; p < 2; p++) begin
      add_gain(0, 0, p, 16'h4000, 16'h0000, 1'b1);
      add_gain(1, 0, p + 2, 16'h4000, 16'h0000, 1'b1);
    end
    for (int p = 0; p < 4; p++) add_sample(0, 0, 1, 0, p, 24'h7FFFFF, 24'h800000);
    add_sample(0, 0, 0, 0, 3, 24'h000001, 24'hFFFFFF);
    add_gain(2, 0, 0, 16'h0001, 16'h0000, 1'b1);
    add_gain(2, 0, 1, 16'h0000, 16'h0000, 1'b1);
    add_sample(2, 0, 1, 0, 2, 24'h010000, 24'h010000);
    add_gain(3, 63, 0, 16'h8000, 16'h8000, 1'b1);
    add_gain(3, 63, 1, 16'h7FFF, 16'h7FFF, 1'b1);
    add_sample(3, 63, 3, 63, 1, 24'h7FFFFF, 24'h7FFFFF);
    add_sample(0, 0, 3, 63, 0, 24'h800000, 24'h123456);
    add_gain(63, 63, 1, 16'h0010, 16'hFFF0, 1'b1);
    add_gain(63, 63, 0, 16'h0010, 16'hFFF0, 1'b0);
    add_sample(63, 63, 0, 0, 1, 24'h400000, 24'h000000);
    add_gain(63, 63, 0, 16'h0010, 16'hFFF0, 1'b1);
    add_sample(63, 63, 0, 0, 2, 24'h400000, 24'h000000);
    drain();

    set_threshold(48'd0);
    add_sample(2, 0, 1, 0, 3, 24'h010000, 24'h010000);
    add_sample(2, 0, 1, 0, 1, 24'h010000, 24'h010000);
    random_phase(150);
    drain();

    set_threshold(48'hFFFFFFFFFFFF);
    send_idle_pct = 59;
    random_phase(150);
    drain();

    set_threshold(48'($urandom_range(1 << 20)));
    send_idle_pct = 0; recv_stall_pct = 59;
    random_phase(150);
    drain();

    set_threshold(48'({$urandom, $urandom}) & 48'h0000FFFFFFFF);
    send_idle_pct = 29; recv_stall_pct = 29;
    random_phase(150);
    drain();

    set_threshold(THR_RESET);
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_recv = 1'b1;
    random_phase(100);
    repeat (300) @(posedge clk);
    hold_recv = 1'b0;
    drain();
    random_phase(80);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/vgc_pkg.sv
hdl/vgc_ifs.sv
hdl/vgc_front.sv
hdl/vgc_fifo.sv
hdl/vgc_div.sv
hdl/vgc_back.sv
hdl/visibility_gain_calibration_unit.sv
verif/visibility_gain_calibration_unit_test.sv
